// ===== hw/rtl/index_page_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Index page allocator assertion macros
// Concurrent assertion helpers used by the allocator datapath.
// ----------------------------------------------------------------------------
`ifndef INDEX_PAGE_ALLOCATOR_MACROS_SVH
`define INDEX_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define IPA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define IPA_ASSERT_SAME(label, clk, rst, ante, cons)
`define IPA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/ipa_pkg.sv =====
// ----------------------------------------------------------------------------
// Index page allocator package
// Sizes, codes and the control types shared by the allocator modules.
// ----------------------------------------------------------------------------
package ipa_pkg;

   // Stack geometry.
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths.
   localparam int LEN_W    = 11;
   localparam int SLOT_W   = 10;
   localparam int STATUS_W = 3;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SLOTS_IN_USE = 1'b0;
   localparam logic [LEN_W-1:0] SLOTS_IN_USE_RESET = LEN_W'(1024);

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_FROM_STACK  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FROM_MARK   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED       = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREED_RESET = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd5;

   // Controller states.
   typedef enum logic [1:0] {
      IPA_IDLE,
      IPA_DECIDE,
      IPA_PUSH,
      IPA_FINISH
   } ipa_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic decide;
      logic push_step;
      logic finish;
   } ipa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_free;
      logic run_done;
      logic out_free;
   } ipa_stat_type;

endpackage

// ===== hw/rtl/ipa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Index page allocator controller
// Sequences one request: load, decide, push the freed run on a free, deliver the beat.
// ----------------------------------------------------------------------------
module ipa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ipa_pkg::ipa_stat_type stat,
   output ipa_pkg::ipa_cmd_type  cmd
);
   import ipa_pkg::*;

   ipa_state_type state_ff;
   ipa_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IPA_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IPA_IDLE: begin
            if (req_valid) state_in = IPA_DECIDE;
         end
         IPA_DECIDE: begin
            state_in = stat.op_free ? IPA_PUSH : IPA_FINISH;
         end
         IPA_PUSH: begin
            if (stat.run_done) state_in = IPA_FINISH;
         end
         IPA_FINISH: begin
            if (stat.out_free) state_in = IPA_IDLE;
         end
         default: state_in = IPA_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         IPA_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         IPA_DECIDE: begin
            cmd.decide = 1'b1;
         end
         IPA_PUSH: begin
            cmd.push_step = 1'b1;
         end
         IPA_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/ipa_datapath.sv =====
// ----------------------------------------------------------------------------
// Index page allocator datapath
// High-water mark, free slot stack memory, run counters and result register.
// ----------------------------------------------------------------------------
`include "index_page_allocator_macros.svh"

module ipa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ipa_pkg::ipa_cmd_type          cmd,
   output ipa_pkg::ipa_stat_type         stat,
   input  logic [ipa_pkg::LEN_W-1:0]     slots_in_use,
   input  logic                          req_op,
   input  logic [ipa_pkg::LEN_W-1:0]     req_run_length,
   input  logic [ipa_pkg::SLOT_W-1:0]    req_first_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ipa_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [ipa_pkg::STATUS_W-1:0]  rsp_status
);
   import ipa_pkg::*;

   logic [SLOT_W-1:0] stack_mem [CAPACITY];

   logic                op_ff;
   logic [LEN_W-1:0]    remaining_ff;
   logic [SLOT_W-1:0]   cur_slot_ff;
   logic                dropped_ff;
   logic [LEN_W-1:0]    mark_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [SLOT_W-1:0]   res_slot_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [SLOT_W-1:0]   rdata_ff;
   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [LEN_W:0]      mark_sum;
   logic                pop_take;
   logic                mark_take;
   logic                run_done;
   logic                stack_full;
   logic                page_match;
   logic                mem_we;
   logic                mem_re;
   logic [CNT_W-1:0]    count_dec;

   // Allocation decision and push bookkeeping.
   assign mark_sum   = {1'b0, mark_ff} + {1'b0, remaining_ff};
   assign pop_take   = (remaining_ff == LEN_W'(1)) && (count_ff != '0);
   assign mark_take  = (remaining_ff != '0) && (mark_sum <= {1'b0, slots_in_use});
   assign run_done   = (remaining_ff == '0);
   assign stack_full = (count_ff == CNT_W'(CAPACITY));
   assign page_match = (count_ff == slots_in_use);
   assign count_dec  = count_ff - CNT_W'(1);
   assign mem_re     = cmd.decide && (op_ff == OP_ALLOC) && pop_take;
   assign mem_we     = cmd.push_step && !run_done && !stack_full;

   assign stat.op_free  = (op_ff == OP_FREE);
   assign stat.run_done = run_done;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   // Free slot stack memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= cur_slot_ff;
      end
      if (mem_re) begin
         rdata_ff <= stack_mem[count_dec[ADDR_W-1:0]];
      end
   end

   // Request capture and run walking.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_op;
         remaining_ff <= req_run_length;
         cur_slot_ff  <= req_first_slot;
         dropped_ff   <= 1'b0;
      end else if (cmd.push_step && !run_done) begin
         remaining_ff <= remaining_ff - LEN_W'(1);
         cur_slot_ff  <= cur_slot_ff + SLOT_W'(1);
         if (stack_full) dropped_ff <= 1'b1;
      end
   end

   // Mark and stack count, plus the pending result of the request.
   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.decide && (op_ff == OP_ALLOC)) begin
         if (pop_take) begin
            count_ff <= count_dec;
         end else if (mark_take) begin
            mark_ff <= mark_sum[LEN_W-1:0];
         end
      end else if (cmd.push_step) begin
         if (!run_done) begin
            if (!stack_full) count_ff <= count_ff + CNT_W'(1);
         end else if (page_match) begin
            mark_ff  <= '0;
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide && (op_ff == OP_ALLOC)) begin
         if (pop_take) begin
            res_slot_ff   <= '0;
            res_status_ff <= ST_FROM_STACK;
         end else if (mark_take) begin
            res_slot_ff   <= mark_ff[SLOT_W-1:0];
            res_status_ff <= ST_FROM_MARK;
         end else begin
            res_slot_ff   <= '0;
            res_status_ff <= ST_NO_ROOM;
         end
      end else if (cmd.push_step && run_done) begin
         res_slot_ff <= '0;
         if (dropped_ff) begin
            res_status_ff <= ST_OVERFLOW;
         end else if (page_match) begin
            res_status_ff <= ST_FREED_RESET;
         end else begin
            res_status_ff <= ST_FREED;
         end
      end
   end

   // Output register: holds a finished beat while the next request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_slot_ff   <= (res_status_ff == ST_FROM_STACK) ? rdata_ff : res_slot_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;

   // The stack never holds more entries than it has rows.
   `IPA_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   // A pop from the stack lowers the count by exactly one.
   `IPA_ASSERT_NEXT(a_pop_dec, clock, reset, mem_re, count_ff == CNT_W'($past(count_ff) - 1'b1))
   // A finished request always shows up as a valid result beat.
   `IPA_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid_ff)

endmodule

// ===== hw/rtl/index_page_allocator.sv =====
// Allocate: the request beat is captured, the decision is made, then the result beat is
// registered; the next request beat can be taken once the controller is back in idle.
// Free: after the decision the pusher walks the run, then the result beat is registered.
// The pusher writes one slot a cycle while the stack has room; a slot beyond it is dropped.
// A request finishes only once the previous result beat has left the output register.
// Reset is synchronous: mark and stack count go to zero, slots_in_use to 1024.
// ----------------------------------------------------------------------------
// Index page allocator top level
// Slot allocator with a high-water mark, a free slot stack and a CSR port.
// ----------------------------------------------------------------------------
module index_page_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_op,
   input  logic [ipa_pkg::LEN_W-1:0]        req_run_length,
   input  logic [ipa_pkg::SLOT_W-1:0]       req_first_slot,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ipa_pkg::SLOT_W-1:0]       rsp_slot_index,
   output logic [ipa_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ipa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ipa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ipa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import ipa_pkg::*;

   ipa_cmd_type      cmd;
   ipa_stat_type     stat;
   logic [LEN_W-1:0] slots_in_use_ff;
   logic             csr_write;

   // Configuration register write on the access phase.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= SLOTS_IN_USE_RESET;
      end else if (csr_write && (csr_paddr[2] == REG_SLOTS_IN_USE)) begin
         slots_in_use_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   // Register read decode.
   always_comb begin
      unique case (csr_paddr[2])
         REG_SLOTS_IN_USE: csr_prdata = CSR_DATA_W'(slots_in_use_ff);
         default:          csr_prdata = '0;
      endcase
   end

   ipa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ipa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .slots_in_use   (slots_in_use_ff),
      .req_op         (req_op),
      .req_run_length (req_run_length),
      .req_first_slot (req_first_slot),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_slot_index (rsp_slot_index),
      .rsp_status     (rsp_status)
   );

endmodule
